[rtl/table_dfa_longest_match_core_defines.svh]
// Assertion macros for the DFA longest-match RTL.
`ifndef TABLE_DFA_LONGEST_MATCH_CORE_DEFINES_SVH
`define TABLE_DFA_LONGEST_MATCH_CORE_DEFINES_SVH

// Condition and consequence checked at the same clock edge.
`define TDLM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdlm: same-cycle check failed");

// Consequence checked at the clock edge after the condition.
`define TDLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdlm: next-cycle check failed");

`endif

[rtl/tdlm_pkg.sv]
// Types and constants shared by the DFA longest-match core and its result queue.
`default_nettype none

package tdlm_pkg;

  // Fixed field widths of the item and result beats.
  localparam int OP_W      = 3;
  localparam int STATE_FW  = 6;
  localparam int SYMBOL_FW = 7;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE_TRANS  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_ACCEPT = 3'd1;
  localparam logic [OP_W-1:0] OP_BEGIN        = 3'd2;
  localparam logic [OP_W-1:0] OP_TEXT         = 3'd3;
  localparam logic [OP_W-1:0] OP_END          = 3'd4;

  // Largest text offset; positions stop here.
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Results that may be held or in flight at once.
  localparam int RESULT_DEPTH = 4;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [STATE_FW-1:0]  table_state;
    logic [SYMBOL_FW-1:0] table_symbol;
    logic [STATE_FW-1:0]  table_next;
    logic                 table_next_valid;
    logic                 accept_value;
    logic [POS_W-1:0]     start_position;
    logic [BYTE_W-1:0]    text_byte;
  } item_t;

  typedef struct packed {
    logic             matched;
    logic [POS_W-1:0] match_begin;
    logic [POS_W-1:0] match_finish;
  } result_t;

  // One transition store entry: a dead entry has valid low.
  typedef struct packed {
    logic                valid;
    logic [STATE_FW-1:0] next;
  } trans_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

`default_nettype wire

[rtl/table_dfa_longest_match_core.sv]
// Table-driven DFA matcher that reports the longest match from a begin position.
//
//   Channel  Direction  Handshake                   Beat payload
//   item     in         item_valid / item_stall     item_t
//   result   out        result_valid / result_stall result_t
//   cfg      in         cfg_we                      cfg_wdata (start state)
//
// One item per cycle sustained while item_stall is low: the transition memory output
// steers the next read address through current_state_next, and the accept flag is
// read one stage later. A result beat passes through stage A, stage B and a 4-entry
// queue after its end beat. After reset a clearing pass, with item_stall high, marks all
// N_STATES * 2**$clog2(N_SYMBOLS) transition entries dead.
// item_stall also rises while four results are queued or in flight; cfg_we is
// taken in every cycle.
`default_nettype none

`include "table_dfa_longest_match_core_defines.svh"

module table_dfa_longest_match_core
  import tdlm_pkg::*;
#(
  parameter int N_STATES  = 64,
  parameter int N_SYMBOLS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [STATE_FW-1:0] cfg_wdata
);

  localparam int STATE_W     = $clog2(N_STATES);
  localparam int SYM_W       = $clog2(N_SYMBOLS);
  localparam int TA_W        = STATE_W + SYM_W;
  localparam int TRANS_DEPTH = N_STATES * (2 ** SYM_W);
  localparam int PEND_W      = $clog2(RESULT_DEPTH + 1);

  // Range checks and address slices for the fixed-width fields.
  function automatic logic state_ok(input logic [STATE_FW-1:0] s);
    return 32'(s) < N_STATES;
  endfunction

  function automatic logic symbol_ok(input logic [BYTE_W-1:0] b);
    return 32'(b) < N_SYMBOLS;
  endfunction

  function automatic logic [STATE_W-1:0] state_idx(input logic [STATE_FW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[STATE_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] sym_idx(input logic [BYTE_W-1:0] b);
    logic [31:0] w;
    w = 32'(b);
    return w[SYM_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? POS_MAX : v + POS_W'(1);
  endfunction

  // Configuration register.
  logic [STATE_FW-1:0] entry_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_state <= '0;
    end else if (cfg_we) begin
      entry_state <= cfg_wdata;
    end
  end

  // Clearing pass over the transition store after reset.
  logic            clearing;
  logic [TA_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + TA_W'(1);
      if (clr_addr == TA_W'(TRANS_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Result credit: end beats accepted but not yet delivered.
  logic              item_accept;
  logic              result_pop;
  logic [PEND_W-1:0] pending;
  logic              end_accept;

  assign item_accept = item_valid && !item_stall;
  assign end_accept  = item_accept && (item.operation == OP_END);
  assign item_stall  = clearing || (pending == PEND_W'(RESULT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(end_accept) - PEND_W'(result_pop);
    end
  end

  // Run state, advanced in stage A.
  logic [STATE_FW-1:0] current_state;
  logic [STATE_FW-1:0] current_state_next;
  logic                run_halted;
  logic                run_halted_next;
  logic [POS_W-1:0]    text_position;
  logic [POS_W-1:0]    text_position_next;

  // Transition memory: written at issue, read at issue, data ready in stage A.
  trans_entry_t    trans_mem [TRANS_DEPTH];
  trans_entry_t    trans_q;
  trans_entry_t    trans_wdata;
  logic            trans_we;
  logic [TA_W-1:0] trans_waddr;
  logic [TA_W-1:0] trans_raddr;

  assign trans_we = clearing ||
                    (item_accept && (item.operation == OP_WRITE_TRANS) &&
                     state_ok(item.table_state) &&
                     symbol_ok(BYTE_W'(item.table_symbol)));
  assign trans_waddr = clearing ? clr_addr
                                : {state_idx(item.table_state),
                                   sym_idx(BYTE_W'(item.table_symbol))};
  assign trans_wdata = clearing ? trans_entry_t'('0)
                                : trans_entry_t'{valid: item.table_next_valid,
                                                 next: item.table_next};
  // The read address follows the state as it will stand after stage A.
  assign trans_raddr = {state_idx(current_state_next), sym_idx(item.text_byte)};

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= trans_wdata;
    end
    trans_q <= trans_mem[trans_raddr];
  end

  // Stage A registers.
  logic                a_valid;
  logic [OP_W-1:0]     a_op;
  logic                a_byte_ok;
  logic [POS_W-1:0]    a_spos;
  logic [STATE_FW-1:0] a_wr_state;
  logic                a_accept_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= item_accept;
    end
  end

  always_ff @(posedge clk) begin
    a_op           <= item.operation;
    a_byte_ok      <= symbol_ok(item.text_byte);
    a_spos         <= item.start_position;
    a_wr_state     <= item.table_state;
    a_accept_value <= item.accept_value;
  end

  // Stage A: step the DFA on the transition read.
  logic cur_ok;
  logic text_live;
  logic text_adv;
  logic text_dead;

  assign cur_ok    = state_ok(current_state);
  assign text_live = a_valid && (a_op == OP_TEXT) && !run_halted && a_byte_ok;
  assign text_adv  = text_live && cur_ok && trans_q.valid;
  assign text_dead = text_live && !(cur_ok && trans_q.valid);

  always_comb begin
    current_state_next = current_state;
    run_halted_next    = run_halted;
    text_position_next = text_position;
    if (a_valid) begin
      case (a_op)
        OP_BEGIN: begin
          current_state_next = entry_state;
          run_halted_next    = 1'b0;
          text_position_next = a_spos;
        end
        OP_TEXT: begin
          if (text_adv) begin
            current_state_next = trans_q.next;
          end else if (text_dead) begin
            run_halted_next = 1'b1;
          end
          text_position_next = sat_inc(text_position);
        end
        OP_END: begin
          run_halted_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= '0;
      run_halted    <= 1'b0;
      text_position <= '0;
    end else begin
      current_state <= current_state_next;
      run_halted    <= run_halted_next;
      text_position <= text_position_next;
    end
  end

  // Accept flag memory: written and read in stage A, data ready in stage B.
  logic                acc_mem [N_STATES];
  logic                acc_q;
  logic                acc_we;
  logic                acc_clr;
  logic [STATE_FW-1:0] acc_rstate;

  assign acc_we     = a_valid && (a_op == OP_WRITE_ACCEPT) && state_ok(a_wr_state);
  assign acc_clr    = clearing && (32'(clr_addr) < N_STATES);
  assign acc_rstate = (a_op == OP_BEGIN) ? entry_state : trans_q.next;

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_mem[clr_addr[STATE_W-1:0]] <= 1'b0;
    end else if (acc_we) begin
      acc_mem[state_idx(a_wr_state)] <= a_accept_value;
    end
    acc_q <= acc_mem[state_idx(acc_rstate)];
  end

  // Stage B registers.
  logic             b_valid;
  logic [OP_W-1:0]  b_op;
  logic             b_adv;
  logic             b_acc_ok;
  logic [POS_W-1:0] b_pos_plus;
  logic [POS_W-1:0] b_spos;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_op       <= a_op;
    b_adv      <= text_adv;
    b_acc_ok   <= (a_op == OP_BEGIN) ? state_ok(entry_state) : state_ok(trans_q.next);
    b_pos_plus <= sat_inc(text_position);
    b_spos     <= a_spos;
  end

  // Stage B: track the longest accepting end and emit results.
  logic             seen_accept;
  logic             seen_accept_next;
  logic [POS_W-1:0] best_end;
  logic [POS_W-1:0] best_end_next;
  logic [POS_W-1:0] run_origin;
  logic [POS_W-1:0] run_origin_next;
  logic             b_hit;

  assign b_hit = b_acc_ok && acc_q;

  always_comb begin
    seen_accept_next = seen_accept;
    best_end_next    = best_end;
    run_origin_next  = run_origin;
    if (b_valid) begin
      case (b_op)
        OP_BEGIN: begin
          seen_accept_next = b_hit;
          best_end_next    = b_spos;
          run_origin_next  = b_spos;
        end
        OP_TEXT: begin
          if (b_adv && b_hit) begin
            seen_accept_next = 1'b1;
            best_end_next    = b_pos_plus;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_accept <= 1'b0;
      best_end    <= '0;
      run_origin  <= '0;
    end else begin
      seen_accept <= seen_accept_next;
      best_end    <= best_end_next;
      run_origin  <= run_origin_next;
    end
  end

  // Result queue.
  logic         b_push;
  result_t      b_result;
  fifo_status_t fifo_st;

  assign b_push   = b_valid && (b_op == OP_END);
  assign b_result = '{matched: seen_accept, match_begin: run_origin, match_finish: best_end};

  tdlm_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (b_push),
    .push_data (b_result),
    .pop       (result_pop),
    .head      (result),
    .status    (fifo_st)
  );

  assign result_valid = !fifo_st.empty;
  assign result_pop   = result_valid && !result_stall;

  // Checks on credit flow, clearing and the halting path.
  `TDLM_ASSERT_IMPLY(a_queue_room, clk, rst, b_push, !fifo_st.full)
  `TDLM_ASSERT_IMPLY(a_result_credit, clk, rst, result_valid, pending != '0)
  `TDLM_ASSERT_IMPLY(a_clear_blocks_items, clk, rst, clearing, !item_accept)
  `TDLM_ASSERT_NEXT(a_dead_halts, clk, rst, text_dead, run_halted)

endmodule

`default_nettype wire

[rtl/tdlm_result_fifo.sv]
// Small result queue that decouples the match pipeline from the result channel.
`default_nettype none

module tdlm_result_fifo
  import tdlm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_t      push_data,
  input  logic         pop,
  output result_t      head,
  output fifo_status_t status
);

  localparam int PTR_W = $clog2(RESULT_DEPTH);
  localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

  result_t            slots [RESULT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  // Storage slots are written at the tail and need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(RESULT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(RESULT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(RESULT_DEPTH));

endmodule

`default_nettype wire

[dv/table_dfa_longest_match_core_tb.sv]
// Self-checking testbench for the DFA longest-match core: directed and random beats vs a predictor.
`default_nettype none

module table_dfa_longest_match_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdlm_pkg::*;

  localparam int NUM_STATES  = 64;
  localparam int NUM_SYMBOLS = 128;

  // Operation codes that the core must ignore.
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 50000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;
  logic                cfg_we       = 1'b0;
  logic [STATE_FW-1:0] cfg_wdata    = '0;

  // Item beats waiting to be driven, and match reports waiting to arrive.
  item_t   item_backlog[$];
  result_t pending_matches[$];

  logic        item_taken     = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned quiet_cycles   = 0;

  // Predictor copy of the matcher state.
  trans_entry_t        trans_mem [NUM_STATES][NUM_SYMBOLS];
  logic                accept_mem [NUM_STATES];
  logic [STATE_FW-1:0] start_reg    = '0;
  logic [STATE_FW-1:0] scan_state   = '0;
  logic                run_accepted = 1'b0;
  logic [POS_W-1:0]    longest_end  = '0;
  logic [POS_W-1:0]    scan_pos     = '0;
  logic                scan_stopped = 1'b0;
  logic [POS_W-1:0]    scan_origin  = '0;

  // States and symbols that the random table of a phase is built on.
  logic [STATE_FW-1:0]  pool [8];
  logic [SYMBOL_FW-1:0] syms [4];

  result_t want;

  table_dfa_longest_match_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [POS_W-1:0] pos_bump(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
  endfunction

  // Advance the predictor by one accepted item beat.
  task automatic dfa_advance(input item_t it);
    trans_entry_t ent;
    case (it.operation)
      OP_WRITE_TRANS: begin
        ent.valid = it.table_next_valid;
        ent.next  = it.table_next_valid ? it.table_next : '0;
        trans_mem[it.table_state][it.table_symbol] = ent;
      end
      OP_WRITE_ACCEPT: begin
        accept_mem[it.table_state] = it.accept_value;
      end
      OP_BEGIN: begin
        scan_state   = start_reg;
        run_accepted = accept_mem[start_reg];
        longest_end  = it.start_position;
        scan_pos     = it.start_position;
        scan_origin  = it.start_position;
        scan_stopped = 1'b0;
      end
      OP_TEXT: begin
        // Bytes outside the alphabet only move the position.
        if (!scan_stopped && !it.text_byte[BYTE_W-1]) begin
          ent = trans_mem[scan_state][it.text_byte[SYMBOL_FW-1:0]];
          if (!ent.valid) begin
            scan_stopped = 1'b1;
          end else begin
            scan_state = ent.next;
            if (accept_mem[scan_state]) begin
              run_accepted = 1'b1;
              longest_end  = pos_bump(scan_pos);
            end
          end
        end
        scan_pos = pos_bump(scan_pos);
      end
      OP_END: begin
        pending_matches.push_back(result_t'{matched: run_accepted, match_begin: scan_origin,
                                            match_finish: longest_end});
        scan_stopped = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    item_taken <= item_valid && !item_stall && !rst;
    if (!rst) begin
      if (cfg_we) begin
        start_reg = cfg_wdata;
      end
      if (item_valid && !item_stall) begin
        dfa_advance(item);
      end
      if (result_valid && !result_stall) begin
        if (pending_matches.size() == 0) begin
          report_mismatch("result beat with no match report outstanding");
        end else begin
          want = pending_matches.pop_front();
          if (result.matched !== want.matched) begin
            report_mismatch($sformatf("matched got %0b want %0b", result.matched,
                                      want.matched));
          end
          if (result.match_begin !== want.match_begin) begin
            report_mismatch($sformatf("match_begin got %h want %h", result.match_begin,
                                      want.match_begin));
          end
          if (result.match_finish !== want.match_finish) begin
            report_mismatch($sformatf("match_finish got %h want %h", result.match_finish,
                                      want.match_finish));
          end
        end
      end
    end
  end

  // Item driver: a beat is held until it is taken, then the next one may follow.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= item_backlog.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Item builders: fields an operation does not use carry random bits.
  function automatic item_t noise_item();
    item_t it;
    it = item_t'({$urandom(), $urandom()});
    return it;
  endfunction

  function automatic item_t make_item(input logic [OP_W-1:0] op);
    item_t it;
    it = noise_item();
    it.operation = op;
    return it;
  endfunction

  function automatic item_t trans_item(input logic [STATE_FW-1:0] s,
                                       input logic [SYMBOL_FW-1:0] sym,
                                       input logic [STATE_FW-1:0] nxt, input logic v);
    item_t it;
    it = make_item(OP_WRITE_TRANS);
    it.table_state      = s;
    it.table_symbol     = sym;
    it.table_next       = nxt;
    it.table_next_valid = v;
    return it;
  endfunction

  function automatic item_t accept_item(input logic [STATE_FW-1:0] s, input logic a);
    item_t it;
    it = make_item(OP_WRITE_ACCEPT);
    it.table_state  = s;
    it.accept_value = a;
    return it;
  endfunction

  function automatic item_t begin_item(input logic [POS_W-1:0] p);
    item_t it;
    it = make_item(OP_BEGIN);
    it.start_position = p;
    return it;
  endfunction

  function automatic item_t text_item(input logic [BYTE_W-1:0] b);
    item_t it;
    it = make_item(OP_TEXT);
    it.text_byte = b;
    return it;
  endfunction

  // Start offsets lean toward both ends so that saturation is reached often.
  function automatic logic [POS_W-1:0] pick_origin();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) begin
      return POS_MAX - POS_W'($urandom_range(15));
    end else if (r < 40) begin
      return POS_W'($urandom_range(15));
    end
    return $urandom();
  endfunction

  // Text bytes mostly come from the symbols the phase table knows.
  function automatic logic [BYTE_W-1:0] pick_text();
    if ($urandom_range(4) != 0) begin
      return {1'b0, syms[$urandom_range(3)]};
    end
    return BYTE_W'($urandom_range(255));
  endfunction

  // Build a dense random DFA over a few states and symbols, starting at start_st.
  task automatic setup_tables(input logic [STATE_FW-1:0] start_st);
    pool[0] = start_st;
    for (int i = 1; i < 8; i++) begin
      pool[i] = STATE_FW'($urandom_range(NUM_STATES - 1));
    end
    for (int k = 0; k < 4; k++) begin
      syms[k] = SYMBOL_FW'($urandom_range(NUM_SYMBOLS - 1));
    end
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 4; k++) begin
        item_backlog.push_back(trans_item(pool[i], syms[k], pool[$urandom_range(7)],
                                          $urandom_range(99) < 85));
      end
      item_backlog.push_back(accept_item(pool[i], $urandom_range(2) == 0));
    end
  endtask

  // Mostly complete match runs, with some noise and broken sequences.
  task automatic gen_runs(input int unsigned n);
    int unsigned target;
    int unsigned len;
    int unsigned r;
    target = item_backlog.size() + n;
    while (item_backlog.size() < target) begin
      r   = $urandom_range(99);
      len = $urandom_range(12, 1);
      if (r < 80) begin
        item_backlog.push_back(begin_item(pick_origin()));
        repeat (len) begin
          // Now and then the table changes in the middle of a run.
          if ($urandom_range(19) == 0) begin
            item_backlog.push_back(trans_item(pool[$urandom_range(7)], syms[$urandom_range(3)],
                                              pool[$urandom_range(7)], 1'b1));
          end
          item_backlog.push_back(text_item(pick_text()));
        end
        item_backlog.push_back(make_item(OP_END));
      end else if (r < 90) begin
        item_backlog.push_back(noise_item());
      end else begin
        case ($urandom_range(2))
          0: begin
            repeat (len) item_backlog.push_back(text_item(pick_text()));
            item_backlog.push_back(make_item(OP_END));
          end
          1: begin
            item_backlog.push_back(make_item(OP_END));
            item_backlog.push_back(make_item(OP_END));
          end
          default: begin
            item_backlog.push_back(begin_item(pick_origin()));
            repeat (len) item_backlog.push_back(text_item(pick_text()));
          end
        endcase
      end
    end
  endtask

  // Wait until every beat is sent and every report has come, then let the pipe empty.
  task automatic wait_quiet();
    do @(negedge clk);
    while (item_backlog.size() != 0 || item_valid || pending_matches.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_start_state(input logic [STATE_FW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [STATE_FW-1:0] st;
    // The store comes out of reset all dead with no accepting state.
    for (int s = 0; s < NUM_STATES; s++) begin
      accept_mem[s] = 1'b0;
      for (int y = 0; y < NUM_SYMBOLS; y++) begin
        trans_mem[s][y] = '0;
      end
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start_state('0);

    // Text before any begin runs from the reset run.
    item_backlog.push_back(trans_item(6'd0, 7'd97, 6'd1, 1'b1));
    item_backlog.push_back(trans_item(6'd1, 7'd98, 6'd2, 1'b1));
    item_backlog.push_back(accept_item(6'd2, 1'b1));
    item_backlog.push_back(text_item(8'd97));
    item_backlog.push_back(text_item(8'd98));
    item_backlog.push_back(make_item(OP_END));
    // Unknown operations do nothing.
    item_backlog.push_back(make_item(OP_RSVD_A));
    item_backlog.push_back(make_item(OP_RSVD_B));
    item_backlog.push_back(make_item(OP_RSVD_C));
    // Field extremes and an explicit dead entry.
    item_backlog.push_back(trans_item(6'd63, 7'd127, 6'd63, 1'b1));
    item_backlog.push_back(accept_item(6'd63, 1'b1));
    item_backlog.push_back(trans_item(6'd2, 7'd99, 6'd0, 1'b0));
    // Saturation near the top offset, a skipped byte, then a dead transition.
    item_backlog.push_back(begin_item(POS_MAX - 2));
    item_backlog.push_back(text_item(8'd97));
    item_backlog.push_back(text_item(8'd200));
    item_backlog.push_back(text_item(8'd98));
    item_backlog.push_back(text_item(8'd99));
    item_backlog.push_back(text_item(8'd255));
    item_backlog.push_back(make_item(OP_END));
    // Bytes after end are ignored and a repeated end reports the same match.
    item_backlog.push_back(text_item(8'd97));
    item_backlog.push_back(make_item(OP_END));
    // Empty run from offset zero, then from the top offset with a dead first byte.
    item_backlog.push_back(begin_item('0));
    item_backlog.push_back(make_item(OP_END));
    item_backlog.push_back(begin_item(POS_MAX));
    item_backlog.push_back(text_item(8'd0));
    item_backlog.push_back(make_item(OP_END));
    wait_quiet();

    // Random phases under different idle patterns and start states.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          st             = 6'd63;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
          st             = STATE_FW'($urandom_range(62, 1));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
          st             = 6'd0;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
          st             = STATE_FW'($urandom_range(NUM_STATES - 1));
        end
      endcase
      write_start_state(st);
      setup_tables(st);
      gen_runs(100);
      // The sender holds off here until every report has come back.
      wait_quiet();
      gen_runs(100);
      wait_quiet();
    end

    repeat (16) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
